@@ sv/rwvi_pkg.sv @@
package rwvi_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;

   // squared distance: three 64-bit squares summed
   localparam int DIST_W  = 66;
   // one sqrt digit per cell, two roots back to back
   localparam int SQRT_STEPS = 32;
   localparam int REM_W      = 35;
   // weighted sum and weight sum, sized for a full table
   localparam int ACC_W   = 64 + CNT_W;
   localparam int WSUM_W  = 32 + CNT_W;
   localparam int DIV_CNT_W = $clog2(ACC_W + 1);

   localparam logic [1:0] CSR_ENTRIES_IN_USE = 2'd0;
   localparam logic [1:0] CSR_RADIUS         = 2'd1;
   localparam logic [1:0] CSR_RADIUS_ROOT    = 2'd2;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef struct packed {
      logic               action;
      logic [9:0]         entry_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] entry_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] interpolated_value;
      logic               used_nearest;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      logic             in_rad;
      logic [31:0]      value;
      logic [63:0]      rad;
      logic [REM_W-1:0] rem;
      logic [31:0]      root;
   } root_link_type;

endpackage

@@ sv/rwvi_sqrt_cell.sv @@
module rwvi_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rwvi_pkg::root_link_type link_in,
   output rwvi_pkg::root_link_type link_out
);
   import rwvi_pkg::*;

   logic [REM_W-1:0] rem_sh;
   logic [REM_W-1:0] trial;
   logic             take;
   root_link_type    link_in_c;
   root_link_type    link_ff;

   // one root digit: bring down two radicand bits, try (root << 2) | 1
   always_comb begin
      rem_sh = {link_in.rem[REM_W-3:0], link_in.rad[63:62]};
      trial  = REM_W'({link_in.root, 2'b01});
      take   = rem_sh >= trial;
      link_in_c        = link_in;
      link_in_c.rad    = {link_in.rad[61:0], 2'b00};
      link_in_c.rem    = take ? rem_sh - trial : rem_sh;
      link_in_c.root   = {link_in.root[30:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in_c.valid;
      end
   end

   always_ff @(posedge clock) begin
      link_ff.in_rad <= link_in_c.in_rad;
      link_ff.value  <= link_in_c.value;
      link_ff.rad    <= link_in_c.rad;
      link_ff.rem    <= link_in_c.rem;
      link_ff.root   <= link_in_c.root;
   end

   assign link_out = link_ff;

endmodule

@@ sv/rwvi_divider.sv @@
module rwvi_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rwvi_pkg::ACC_W-1:0]  dividend,
   input  logic [rwvi_pkg::WSUM_W-1:0] divisor,
   output logic                        done,
   output logic [31:0]                 quotient
);
   import rwvi_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [WSUM_W-1:0]    rem_ff;
   logic [ACC_W-1:0]     dvd_ff;
   logic [31:0]          quot_ff;
   logic [WSUM_W:0]      rem_sh;
   logic                 qbit;
   logic [WSUM_W:0]      rem_in;

   // restoring division, one quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, dvd_ff[ACC_W-1]};
      qbit   = rem_sh >= {1'b0, divisor};
      rem_in = qbit ? rem_sh - {1'b0, divisor} : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff  <= DIV_CNT_W'(ACC_W);
         rem_ff  <= '0;
         dvd_ff  <= dividend;
         quot_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - DIV_CNT_W'(1);
         rem_ff  <= rem_in[WSUM_W-1:0];
         dvd_ff  <= {dvd_ff[ACC_W-2:0], 1'b0};
         quot_ff <= {quot_ff[30:0], qbit};
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

@@ sv/radius_weighted_value_interpolation.sv @@
// channel  ports                                      direction  handshake
// req      start, busy, req_word                      in         start & !busy
// rsp      rsp_valid, rsp_word                        out        strobe, one cycle
// csr      csr_valid, csr_ready, csr_index, csr_data  in         valid & ready
//
// A load writes one table entry. A query walks n = min(entries_in_use, 1024)
// table entries, one per cycle through the memory read port, then drains the
// distance stages, the 64-cell square-root row and the weight stages, then a
// bit-serial divider, which is skipped when no entry has positive weight.
// Reset is synchronous; the table is not cleared. rsp has no back pressure;
// busy stays high through the strobe cycle.
module radius_weighted_value_interpolation (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rwvi_pkg::req_type   req_word,
   output logic                rsp_valid,
   output rwvi_pkg::rsp_type   rsp_word,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_data
);
   import rwvi_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [CNT_W-1:0] entries_ff;
   logic [31:0] radius_ff, radius_root_ff;
   logic [63:0] r2_ff;

   logic        accept, load, query;
   logic [127:0] table_mem [TABLE_DEPTH];
   logic [127:0] rd_ff;

   logic [31:0] qx_ff, qy_ff, qz_ff;
   logic [CNT_W-1:0] n_ff, idx_ff, inflight_ff;
   logic        issue, retire, scan_done;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic [32:0] dx, dy, dz;
   logic [31:0] mx_ff, my_ff, mz_ff, val1_ff, val2_ff, val3_ff;
   logic [63:0] sx_ff, sy_ff, sz_ff;
   logic [DIST_W-1:0] dist_ff;
   logic        in_rad;

   logic        have_best_ff;
   logic [DIST_W-1:0] best_d_ff;
   logic [31:0] best_val_ff;

   root_link_type link [2*SQRT_STEPS+1];
   root_link_type cell_in [2*SQRT_STEPS];

   logic        wv_ff, wc_ff, wneg_ff;
   logic [31:0] w_ff, wabs_ff;
   logic        mv_ff, mc_ff, mneg_ff;
   logic [31:0] mw_ff;
   logic [63:0] prod_ff;
   logic        nv_ff;
   logic [ACC_W-1:0] term_ff, acc_ff, acc_mag;
   logic [31:0] nw_ff;
   logic [WSUM_W-1:0] wsum_ff;

   logic        div_start, div_done;
   logic [31:0] quot;
   logic [31:0] q_sat;
   rsp_type     result_ff;

   assign busy      = state_ff != ST_IDLE;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign load      = accept && req_word.action == ACTION_LOAD;
   assign query     = accept && req_word.action == ACTION_QUERY;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff     <= '0;
         radius_ff      <= '0;
         radius_root_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENTRIES_IN_USE: entries_ff     <= csr_data[CNT_W-1:0];
            CSR_RADIUS:         radius_ff      <= csr_data;
            CSR_RADIUS_ROOT:    radius_root_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      r2_ff <= radius_ff * radius_ff;
   end

   // table word: {value, z, y, x}
   always_ff @(posedge clock) begin
      if (load) begin
         table_mem[req_word.entry_index[ADDR_W-1:0]] <=
            {req_word.entry_value, req_word.pos_z, req_word.pos_y, req_word.pos_x};
      end
      rd_ff <= table_mem[idx_ff[ADDR_W-1:0]];
   end

   assign issue     = state_ff == ST_SCAN && idx_ff < n_ff;
   assign retire    = nv_ff;
   assign scan_done = state_ff == ST_SCAN && !issue && inflight_ff == '0;
   assign div_start = scan_done && wsum_ff != '0;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (query) state_in = ST_SCAN;
         ST_SCAN: if (scan_done) state_in = (wsum_ff != '0) ? ST_DIV : ST_OUT;
         ST_DIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         inflight_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         wv_ff <= 1'b0;
         mv_ff <= 1'b0;
         nv_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         inflight_ff <= inflight_ff + CNT_W'(issue) - CNT_W'(retire);
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         wv_ff <= link[2*SQRT_STEPS].valid;
         mv_ff <= wv_ff;
         nv_ff <= mv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (query) begin
         qx_ff  <= req_word.pos_x;
         qy_ff  <= req_word.pos_y;
         qz_ff  <= req_word.pos_z;
         n_ff   <= (entries_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entries_ff;
         idx_ff <= '0;
      end else if (issue) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   // distance stages: difference, square, sum
   always_comb begin
      dx = {rd_ff[31], rd_ff[31:0]}   - {qx_ff[31], qx_ff};
      dy = {rd_ff[63], rd_ff[63:32]}  - {qy_ff[31], qy_ff};
      dz = {rd_ff[95], rd_ff[95:64]}  - {qz_ff[31], qz_ff};
   end

   always_ff @(posedge clock) begin
      mx_ff   <= dx[32] ? 32'(-dx) : dx[31:0];
      my_ff   <= dy[32] ? 32'(-dy) : dy[31:0];
      mz_ff   <= dz[32] ? 32'(-dz) : dz[31:0];
      val1_ff <= rd_ff[127:96];
      sx_ff   <= mx_ff * mx_ff;
      sy_ff   <= my_ff * my_ff;
      sz_ff   <= mz_ff * mz_ff;
      val2_ff <= val1_ff;
      dist_ff <= DIST_W'(sx_ff) + DIST_W'(sy_ff) + DIST_W'(sz_ff);
      val3_ff <= val2_ff;
   end

   assign in_rad = dist_ff[DIST_W-1:64] == '0 && dist_ff[63:0] < r2_ff;

   // nearest entry, first one wins a tie
   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
      end else if (query) begin
         have_best_ff <= 1'b0;
      end else if (v4_ff) begin
         have_best_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (v4_ff && (!have_best_ff || dist_ff < best_d_ff)) begin
         best_d_ff   <= dist_ff;
         best_val_ff <= val3_ff;
      end
   end

   always_comb begin
      link[0].valid  = v4_ff;
      link[0].in_rad = in_rad;
      link[0].value  = val3_ff;
      link[0].rad    = dist_ff[63:0];
      link[0].rem    = '0;
      link[0].root   = '0;
   end

   // first half: distance = sqrt(D); second half: root = sqrt(distance << 16)
   for (genvar g = 0; g < 2*SQRT_STEPS; g++) begin : g_cell
      if (g == SQRT_STEPS) begin : g_seam
         always_comb begin
            cell_in[g]      = link[g];
            cell_in[g].rad  = {16'b0, link[g].root, 16'b0};
            cell_in[g].rem  = '0;
            cell_in[g].root = '0;
         end
      end else begin : g_pass
         assign cell_in[g] = link[g];
      end
      rwvi_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .link_in  (cell_in[g]),
         .link_out (link[g+1])
      );
   end

   // weight, product, signed term, accumulate
   always_ff @(posedge clock) begin
      wc_ff   <= link[2*SQRT_STEPS].in_rad && radius_root_ff > link[2*SQRT_STEPS].root;
      w_ff    <= radius_root_ff - link[2*SQRT_STEPS].root;
      wneg_ff <= link[2*SQRT_STEPS].value[31];
      wabs_ff <= link[2*SQRT_STEPS].value[31] ? 32'(-link[2*SQRT_STEPS].value)
                                              : link[2*SQRT_STEPS].value;
      mc_ff   <= wc_ff;
      mneg_ff <= wneg_ff;
      mw_ff   <= w_ff;
      prod_ff <= wabs_ff * w_ff;
      if (!mc_ff) begin
         term_ff <= '0;
         nw_ff   <= '0;
      end else begin
         term_ff <= mneg_ff ? ACC_W'(-ACC_W'(prod_ff)) : ACC_W'(prod_ff);
         nw_ff   <= mw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (query) begin
         acc_ff  <= '0;
         wsum_ff <= '0;
      end else if (nv_ff) begin
         acc_ff  <= acc_ff + term_ff;
         wsum_ff <= wsum_ff + WSUM_W'(nw_ff);
      end
   end

   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;

   rwvi_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_mag),
      .divisor  (wsum_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_comb begin
      if (acc_ff[ACC_W-1]) begin
         q_sat = (quot > 32'h8000_0000) ? 32'h8000_0000 : quot;
         q_sat = 32'(-q_sat);
      end else begin
         q_sat = (quot > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot;
      end
   end

   always_ff @(posedge clock) begin
      if (scan_done && wsum_ff == '0) begin
         result_ff.interpolated_value <= have_best_ff ? best_val_ff : '0;
         result_ff.used_nearest       <= 1'b1;
      end else if (div_done) begin
         result_ff.interpolated_value <= q_sat;
         result_ff.used_nearest       <= 1'b0;
      end
   end

   assign rsp_valid = state_ff == ST_OUT;
   assign rsp_word  = result_ff;

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy |-> inflight_ff == '0)
      else $error("entries in flight while idle");

   a_weighted_has_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.used_nearest |-> wsum_ff != '0)
      else $error("weighted result with zero weight sum");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside divide state");
`endif

endmodule

@@ tb/rwvi_checker.sv @@
`timescale 1ns / 100ps

module rwvi_checker
   import rwvi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  req_type     req_word,
   input  logic        rsp_valid,
   input  rsp_type     rsp_word,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending
);

   logic [31:0] pt_x [TABLE_DEPTH];
   logic [31:0] pt_y [TABLE_DEPTH];
   logic [31:0] pt_z [TABLE_DEPTH];
   logic [31:0] pt_val [TABLE_DEPTH];
   logic [10:0] scan_count;
   logic [31:0] rad_q;
   logic [31:0] rad_root_q;
   rsp_type     expected_values [$];

   assign pending = expected_values.size();

   // digit-by-digit integer square root
   function automatic logic [31:0] int_sqrt(input logic [63:0] v);
      logic [65:0] rem;
      logic [65:0] trial;
      logic [31:0] r;
      rem = '0;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         rem = (rem << 2) | v[2*i +: 2];
         trial = {32'b0, r, 2'b01};
         if (rem >= trial) begin
            rem = rem - trial;
            r = (r << 1) | 1'b1;
         end else begin
            r = r << 1;
         end
      end
      return r;
   endfunction

   function automatic logic [63:0] axis_sq(input logic [31:0] a, input logic [31:0] b);
      logic signed [33:0] diff;
      logic [33:0]        mag;
      diff = 34'($signed(a)) - 34'($signed(b));
      mag = diff[33] ? -diff : diff;
      return 64'(mag[31:0]) * 64'(mag[31:0]) + (mag[32] ? 64'h0 : 64'h0);
   endfunction

   function automatic rsp_type interpolate(input req_type q);
      rsp_type             res;
      logic [65:0]         sq_dist;
      logic [65:0]         best;
      logic [31:0]         best_val;
      logic                have_best;
      logic [63:0]         r2;
      logic [31:0]         d;
      logic [31:0]         rt;
      logic [31:0]         w;
      logic signed [127:0] acc;
      logic [127:0]        mag;
      logic [127:0]        quo;
      logic [63:0]         wsum;
      int                  n;
      n = scan_count > TABLE_DEPTH ? TABLE_DEPTH : int'(scan_count);
      r2 = 64'(rad_q) * 64'(rad_q);
      acc = '0;
      wsum = '0;
      have_best = 1'b0;
      best = '0;
      best_val = '0;
      for (int i = 0; i < n; i++) begin
         sq_dist = 66'(axis_sq(pt_x[i], q.pos_x)) + 66'(axis_sq(pt_y[i], q.pos_y))
                 + 66'(axis_sq(pt_z[i], q.pos_z));
         if (!have_best || sq_dist < best) begin
            have_best = 1'b1;
            best = sq_dist;
            best_val = pt_val[i];
         end
         if (sq_dist < {2'b0, r2}) begin
            d = int_sqrt(sq_dist[63:0]);
            rt = int_sqrt({16'b0, d, 16'b0});
            if (rad_root_q > rt) begin
               w = rad_root_q - rt;
               acc = acc + 128'($signed(pt_val[i])) * $signed({96'b0, w});
               wsum = wsum + 64'(w);
            end
         end
      end
      if (wsum == 0) begin
         res.interpolated_value = have_best ? best_val : 32'sd0;
         res.used_nearest = 1'b1;
      end else begin
         mag = acc < 0 ? -acc : acc;
         quo = mag / {64'b0, wsum};
         if (acc < 0) begin
            if (quo > 128'h8000_0000) quo = 128'h8000_0000;
            res.interpolated_value = -quo[31:0];
         end else begin
            if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
            res.interpolated_value = quo[31:0];
         end
         res.used_nearest = 1'b0;
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         scan_count <= '0;
         rad_q <= '0;
         rad_root_q <= '0;
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ENTRIES_IN_USE: scan_count <= csr_data[10:0];
               CSR_RADIUS:         rad_q <= csr_data;
               CSR_RADIUS_ROOT:    rad_root_q <= csr_data;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_word.action == ACTION_LOAD) begin
               pt_x[req_word.entry_index] <= req_word.pos_x;
               pt_y[req_word.entry_index] <= req_word.pos_y;
               pt_z[req_word.entry_index] <= req_word.pos_z;
               pt_val[req_word.entry_index] <= req_word.entry_value;
            end else begin
               expected_values = {expected_values, interpolate(req_word)};
            end
         end
         if (rsp_valid) begin
            if (expected_values.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("unexpected word: value %h nearest %b",
                           rsp_word.interpolated_value, rsp_word.used_nearest);
            end else begin
               want = expected_values.pop_front();
               if (want != rsp_word) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: expected value %h nearest %b, got value %h nearest %b",
                              want.interpolated_value, want.used_nearest,
                              rsp_word.interpolated_value, rsp_word.used_nearest);
               end
            end
         end
      end
   end

endmodule

@@ tb/radius_weighted_value_interpolation_tb.sv @@
`timescale 1ns / 100ps

module radius_weighted_value_interpolation_tb;
   import rwvi_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_word = '0;
   logic        rsp_valid;
   rsp_type     rsp_word;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_ENTRIES_IN_USE;
   logic [31:0] csr_data = '0;
   int          fail_count;
   int          pending;
   int          gap_pct = 0;

   always #5 clock = ~clock;

   radius_weighted_value_interpolation u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   rwvi_checker u_chk (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_word(rsp_word), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   function automatic req_type mk(input logic act, input logic [9:0] idx,
                                  input logic [31:0] x, input logic [31:0] y,
                                  input logic [31:0] z, input logic [31:0] v);
      req_type w;
      w.action = act;
      w.entry_index = idx;
      w.pos_x = x;
      w.pos_y = y;
      w.pos_z = z;
      w.entry_value = v;
      return w;
   endfunction

   function automatic logic [31:0] near(input logic [31:0] c, input int unsigned s);
      return c + $urandom_range(0, 2 * s) - s;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send(input req_type w);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      start <= 1'b1;
      req_word <= w;
      // hold the word until busy is low at a falling edge; it goes in at the next rise
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   // drain: no word in flight, then a short pause
   task automatic settle();
      start <= 1'b0;
      while (busy || pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic setup(input logic [10:0] n, input logic [31:0] r,
                        input logic [31:0] root);
      write_reg(CSR_ENTRIES_IN_USE, 32'(n));
      write_reg(CSR_RADIUS, r);
      write_reg(CSR_RADIUS_ROOT, root);
   endtask

   initial begin
      #50ms;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      logic [31:0] cx, cy, cz, root, rad;
      int unsigned spread;
      int          n;
      int          pick;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table
      send(mk(ACTION_QUERY, 10'h3FF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0));
      send(mk(ACTION_LOAD, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send(mk(ACTION_LOAD, 10'd1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send(mk(ACTION_LOAD, 10'd2, 32'h0, 32'h0, 32'h0, 32'h0001_0000));
      // twin of entry 2: equal distance, first one must win
      send(mk(ACTION_LOAD, 10'd3, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000));
      setup(11'd4, 32'h0, 32'h0);
      send(mk(ACTION_QUERY, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0));
      send(mk(ACTION_QUERY, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
      send(mk(ACTION_QUERY, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
      setup(11'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(mk(ACTION_QUERY, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
      send(mk(ACTION_QUERY, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0));
      send(mk(ACTION_QUERY, 10'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0));
      setup(11'd3, 32'h0001_0000, 32'h0001_0000);
      send(mk(ACTION_QUERY, 10'd0, 32'h0000_8000, 32'h0, 32'h0, 32'h0));
      send(mk(ACTION_QUERY, 10'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0));
      send(mk(ACTION_QUERY, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
      setup(11'd4, 32'h0001_0000, 32'h0);
      send(mk(ACTION_QUERY, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));

      for (int ph = 0; ph < 16; ph++) begin
         case (ph % 4)
            0: gap_pct = 0;
            1: gap_pct = 52;
            2: gap_pct = 0;
            default: gap_pct = 34;
         endcase
         n = (ph == 5) ? 1 : $urandom_range(1, 12);
         root = $urandom_range(1 << 8, 1 << 19);
         rad = 32'((64'(root) * 64'(root)) >> 16);
         spread = rad / $urandom_range(1, 3) + 1;
         cx = $urandom;
         cy = $urandom;
         cz = $urandom;
         settle();
         for (int i = 0; i < n; i++)
            send(mk(ACTION_LOAD, 10'(i), near(cx, spread), near(cy, spread),
                    near(cz, spread), rand_value()));
         case ($urandom_range(0, 7))
            0: root = $urandom;
            1: root = '0;
            default: ;
         endcase
         setup(11'(n), rad, root);
         for (int k = 0; k < 24; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
               send(mk(ACTION_LOAD, 10'($urandom_range(0, n - 1)), near(cx, spread),
                       near(cy, spread), near(cz, spread), rand_value()));
            else if (pick < 75)
               send(mk(ACTION_QUERY, 10'($urandom), near(cx, 2 * spread),
                       near(cy, 2 * spread), near(cz, 2 * spread), $urandom));
            else if (pick < 88)
               send(mk(ACTION_QUERY, 10'($urandom), $urandom, $urandom, $urandom, $urandom));
            else
               send(mk(ACTION_QUERY, 10'($urandom), cx, cy, cz, $urandom));
         end
      end

      // fill a larger block of the table, then scan all of it
      gap_pct = 0;
      settle();
      cx = $urandom;
      for (int i = 0; i < 48; i++)
         send(mk(ACTION_LOAD, 10'(i), near(cx, 1 << 20), near(cx, 1 << 20),
                 near(cx, 1 << 20), $urandom));
      setup(11'd48, 32'h0020_0000, 32'h0016_A09E);
      repeat (3)
         send(mk(ACTION_QUERY, 10'd0, near(cx, 1 << 20), near(cx, 1 << 20),
                 near(cx, 1 << 20), 32'h0));
      setup(11'd48, 32'h0000_0100, 32'h0000_1000);
      repeat (2)
         send(mk(ACTION_QUERY, 10'd0, near(cx, 1 << 20), near(cx, 1 << 20),
                 near(cx, 1 << 20), 32'h0));

      settle();
      repeat (200) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ radius_weighted_value_interpolation.f @@
sv/rwvi_pkg.sv
sv/rwvi_sqrt_cell.sv
sv/rwvi_divider.sv
sv/radius_weighted_value_interpolation.sv
tb/rwvi_checker.sv
tb/radius_weighted_value_interpolation_tb.sv
